/* hdl/lirs_pkg.sv */
// Shared constants, register codes and sequencer states of the linear
// interpolation resampler. No dependencies.
`default_nettype none

package lirs_pkg;

  localparam int unsigned SAMPLE_W = 24;              // sample width
  localparam int unsigned DIFF_W   = SAMPLE_W + 1;    // sample difference / magnitude
  localparam int unsigned RATE_W   = 18;              // rate register width
  localparam int unsigned LEN_W    = 16;              // block length / input count
  localparam int unsigned POS_W    = 22;              // output slot index
  localparam int unsigned PROD_W   = RATE_W + LEN_W;  // serial product / dividend
  localparam int unsigned MAX_RUN  = 64;              // results caused by one input
  localparam int unsigned RUN_W    = 7;               // holds 0..MAX_RUN
  localparam int unsigned CNT_W    = 6;               // bit step counter
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [RATE_W-1:0] SRC_RATE_RST  = RATE_W'(48000);
  localparam logic [RATE_W-1:0] TGT_RATE_RST  = RATE_W'(48000);
  localparam logic [LEN_W-1:0]  BLOCK_LEN_RST = LEN_W'(1024);
  localparam logic [POS_W-1:0]  POS_MAX       = '1;

  typedef enum logic [1:0] {
    REG_SRC_RATE  = 2'd0,
    REG_TGT_RATE  = 2'd1,
    REG_BLOCK_LEN = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,     // shift-add, one multiplier bit per cycle
    ST_DIV,     // restoring divide, one quotient bit per cycle
    ST_LIMIT,   // first input of a block
    ST_POS,     // slot decision for later inputs
    ST_CLAMP,
    ST_SETUP,
    ST_STEP,    // advance interpolation fraction
    ST_EMIT,    // interpolated result
    ST_FINAL,   // input itself at its slot
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* hdl/linear_interp_resampler.sv */
// Linear interpolation sample rate converter, one block of one channel.
// Depends on lirs_pkg.
`default_nettype none

// Each input sample is processed by a sequencer around one bit-serial
// shift-add multiplier and one restoring divider that yields one quotient
// bit per cycle. An inactive input after the block has overrun skips both
// and goes straight to ST_DONE; every other input is multiplied, then
// divided. When upsampling, an input that yields interpolated results
// goes through the divider once more: the step size is divided once, then
// each interpolated value is an accumulate of quotient and remainder. An
// output stall holds the sequencer whenever a further result is to be
// written. Results sit in an output register, so the next sample is taken
// while the last result of the previous one still waits. Rate and length
// registers are to be written over the APB port only while no sample is in
// flight; the user is bound to this, the block itself does not enforce it.
module linear_interp_resampler
  import lirs_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [PADDR_W-1:0]   paddr,
  input  wire [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // input samples
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire [SAMPLE_W-1:0]  sample_in_i,
  // results
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [POS_W-1:0]    out_position_o,
  output logic [SAMPLE_W-1:0] sample_out_o,
  output logic                run_last_o,
  output logic                block_done_o
);

  state_e state_q, state_d;

  logic [RATE_W-1:0] src_rate_q, tgt_rate_q;
  logic [LEN_W-1:0]  block_len_q;
  logic [RATE_W-1:0] src_eff;
  logic [LEN_W-1:0]  len_eff;
  logic              cfg_wr;

  logic [SAMPLE_W-1:0] prev_q, prev_d, cur_q, cur_d;
  logic [LEN_W-1:0]    count_q, count_d;
  logic [POS_W-1:0]    last_pos_q, last_pos_d, limit_q, limit_d;
  logic                stopped_q, stopped_d;
  logic                first_q, first_d, end_q, end_d, frac_q, frac_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d, left_q, left_d;

  logic [PROD_W-1:0]   acc_q, acc_d;
  logic [RATE_W-1:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [POS_W-1:0]    np_q, np_d, pos_q, pos_d;
  logic [DIFF_W-1:0]   diff_q, diff_d, fq_q, fq_d;
  logic [RUN_W-1:0]    fr_q, fr_d;
  logic                neg_q, neg_d;

  logic                ov_q, ov_d;
  logic [POS_W-1:0]    opos_q, opos_d;
  logic [SAMPLE_W-1:0] osmp_q, osmp_d;
  logic                olast_q, olast_d, odone_q, odone_d;

  // datapath terms
  logic                ofree, accept;
  logic [RATE_W:0]     msum, rem_sh, rdiff;
  logic [POS_W:0]      last_p1, last_run, np_a, np_b;
  logic [PROD_W:0]     ceil_q;
  logic [POS_W-1:0]    lim_m1, span;
  logic [RUN_W:0]      fr_sum;
  logic [DIFF_W-1:0]   absdiff, ival;
  logic [RUN_W-1:0]    span_m2;
  logic                fr_wrap;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_SRC_RATE:  prdata = PDATA_W'(src_rate_q);
      REG_TGT_RATE:  prdata = PDATA_W'(tgt_rate_q);
      REG_BLOCK_LEN: prdata = PDATA_W'(block_len_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate_q  <= SRC_RATE_RST;
      tgt_rate_q  <= TGT_RATE_RST;
      block_len_q <= BLOCK_LEN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_SRC_RATE:  src_rate_q  <= pwdata[RATE_W-1:0];
        REG_TGT_RATE:  tgt_rate_q  <= pwdata[RATE_W-1:0];
        REG_BLOCK_LEN: block_len_q <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign src_eff = (src_rate_q == '0) ? RATE_W'(1) : src_rate_q;
  assign len_eff = (block_len_q == '0) ? LEN_W'(1) : block_len_q;

  // ---------------------------------------------------------------- handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign ofree      = !ov_q || !out_stall_i;

  assign out_valid_o    = ov_q;
  assign out_position_o = opos_q;
  assign sample_out_o   = osmp_q;
  assign run_last_o     = olast_q;
  assign block_done_o   = odone_q;

  // ---------------------------------------------------------------- arithmetic
  assign msum    = {1'b0, acc_q[PROD_W-1:LEN_W]} + {1'b0, tgt_rate_q};
  assign rem_sh  = {rem_q, acc_q[PROD_W-1]};
  assign rdiff   = rem_sh - {1'b0, dvs_q};

  assign last_p1  = {1'b0, last_pos_q} + (POS_W+1)'(1);
  assign last_run = {1'b0, last_pos_q} + (POS_W+1)'(MAX_RUN);
  assign ceil_q   = {1'b0, acc_q} + (PROD_W+1)'(rem_q != '0);
  assign lim_m1   = (limit_q == '0) ? '0 : limit_q - POS_W'(1);

  assign np_a = ({1'b0, np_q} > last_run) ? last_run : {1'b0, np_q};
  assign np_b = (np_a < {1'b0, last_pos_q}) ? {1'b0, last_pos_q} : np_a;

  assign span    = np_q - last_pos_q;
  assign span_m2 = span[RUN_W-1:0] - RUN_W'(2);
  assign absdiff = diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;

  // after the step division acc holds the whole part, rem the remainder
  assign fr_sum  = {1'b0, fr_q} + {1'b0, rem_q[RUN_W-1:0]};
  assign fr_wrap = (fr_sum >= {1'b0, dvs_q[RUN_W-1:0]});
  assign ival    = neg_q ? ({prev_q[SAMPLE_W-1], prev_q} - fq_q)
                         : ({prev_q[SAMPLE_W-1], prev_q} + fq_q);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    count_d    = count_q;
    last_pos_d = last_pos_q;
    limit_d    = limit_q;
    stopped_d  = stopped_q;
    first_d    = first_q;
    end_d      = end_q;
    frac_d     = frac_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    np_d       = np_q;
    pos_d      = pos_q;
    diff_d     = diff_q;
    fq_d       = fq_q;
    fr_d       = fr_q;
    neg_d      = neg_q;
    ov_d       = ov_q && out_stall_i;
    opos_d     = opos_q;
    osmp_d     = osmp_q;
    olast_d    = olast_q;
    odone_d    = odone_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cur_d   = sample_in_i;
          first_d = (count_q == '0);
          end_d   = (({1'b0, count_q} + (LEN_W+1)'(1)) >= {1'b0, len_eff});
          acc_d   = {RATE_W'(0), (count_q == '0) ? len_eff : count_q};
          cnt_d   = '0;
          frac_d  = 1'b0;
          if (count_q != '0 && stopped_q) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        if (acc_q[0]) begin
          acc_d = {msum, acc_q[LEN_W-1:1]};
        end else begin
          acc_d = {1'b0, acc_q[PROD_W-1:1]};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(LEN_W - 1)) begin
          cnt_d   = '0;
          dvs_d   = src_eff;
          rem_d   = '0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        if (!rdiff[RATE_W]) begin
          rem_d = rdiff[RATE_W-1:0];
          acc_d = {acc_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[RATE_W-1:0];
          acc_d = {acc_q[PROD_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          cnt_d = '0;
          if (frac_q) begin
            state_d = ST_STEP;
          end else if (first_q) begin
            state_d = ST_LIMIT;
          end else begin
            state_d = ST_POS;
          end
        end
      end

      ST_LIMIT: begin
        limit_d    = (acc_q[PROD_W-1:POS_W] != '0) ? POS_MAX : acc_q[POS_W-1:0];
        stopped_d  = 1'b0;
        last_pos_d = '0;
        if (ofree) begin
          ov_d    = 1'b1;
          opos_d  = '0;
          osmp_d  = cur_q;
          olast_d = 1'b1;
          odone_d = end_q;
          state_d = ST_DONE;
        end
      end

      ST_POS: begin
        diff_d = {cur_q[SAMPLE_W-1], cur_q} - {prev_q[SAMPLE_W-1], prev_q};
        np_d   = (ceil_q > (PROD_W+1)'(lim_m1)) ? lim_m1 : ceil_q[POS_W-1:0];
        if (tgt_rate_q <= src_eff) begin
          // reached the next slot when floor(k*tgt/src) >= last+1
          if (acc_q >= PROD_W'(last_p1)) begin
            if (last_p1 >= {1'b0, limit_q}) begin
              stopped_d = 1'b1;
              state_d   = ST_DONE;
            end else if (ofree) begin
              ov_d       = 1'b1;
              opos_d     = last_p1[POS_W-1:0];
              osmp_d     = cur_q;
              olast_d    = 1'b1;
              odone_d    = end_q;
              last_pos_d = last_p1[POS_W-1:0];
              state_d    = ST_DONE;
            end
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_CLAMP;
        end
      end

      ST_CLAMP: begin
        np_d    = np_b[POS_W-1:0];
        state_d = ST_SETUP;
      end

      ST_SETUP: begin
        if (span[RUN_W-1:0] >= RUN_W'(2)) begin
          acc_d   = PROD_W'(absdiff);
          dvs_d   = RATE_W'(span[RUN_W-1:0]);
          rem_d   = '0;
          cnt_d   = '0;
          frac_d  = 1'b1;
          fq_d    = '0;
          fr_d    = '0;
          neg_d   = diff_q[DIFF_W-1];
          pos_d   = last_p1[POS_W-1:0];
          left_d  = span_m2[CNT_W-1:0];
          state_d = ST_DIV;
        end else begin
          state_d = ST_FINAL;
        end
      end

      ST_STEP: begin
        if (fr_wrap) begin
          fr_d = RUN_W'(fr_sum - {1'b0, dvs_q[RUN_W-1:0]});
        end else begin
          fr_d = fr_sum[RUN_W-1:0];
        end
        fq_d    = fq_q + acc_q[DIFF_W-1:0] + DIFF_W'(fr_wrap);
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (ofree) begin
          ov_d    = 1'b1;
          opos_d  = pos_q;
          osmp_d  = ival[SAMPLE_W-1:0];
          olast_d = 1'b0;
          odone_d = end_q;
          pos_d   = pos_q + POS_W'(1);
          if (left_q == '0) begin
            state_d = ST_FINAL;
          end else begin
            left_d  = left_q - CNT_W'(1);
            state_d = ST_STEP;
          end
        end
      end

      ST_FINAL: begin
        if (ofree) begin
          ov_d       = 1'b1;
          opos_d     = np_q;
          osmp_d     = cur_q;
          olast_d    = 1'b1;
          odone_d    = end_q;
          last_pos_d = np_q;
          state_d    = ST_DONE;
        end
      end

      ST_DONE: begin
        prev_d  = cur_q;
        count_d = end_q ? '0 : count_q + LEN_W'(1);
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      count_q    <= '0;
      last_pos_q <= '0;
      limit_q    <= '0;
      stopped_q  <= 1'b0;
      first_q    <= 1'b0;
      end_q      <= 1'b0;
      frac_q     <= 1'b0;
      cnt_q      <= '0;
      left_q     <= '0;
      ov_q       <= 1'b0;
    end else begin
      prev_q     <= prev_d;
      count_q    <= count_d;
      last_pos_q <= last_pos_d;
      limit_q    <= limit_d;
      stopped_q  <= stopped_d;
      first_q    <= first_d;
      end_q      <= end_d;
      frac_q     <= frac_d;
      cnt_q      <= cnt_d;
      left_q     <= left_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    np_q    <= np_d;
    pos_q   <= pos_d;
    diff_q  <= diff_d;
    fq_q    <= fq_d;
    fr_q    <= fr_d;
    neg_q   <= neg_d;
    opos_q  <= opos_d;
    osmp_q  <= osmp_d;
    olast_q <= olast_d;
    odone_q <= odone_d;
  end

endmodule

`default_nettype wire

/* bench/tb_linear_interp_resampler.sv */
// Self-checking bench for linear_interp_resampler: a directed script, then random
// rate/length settings, with results checked against an in-bench interpolation model.
// Depends on lirs_pkg and the resampler RTL.
`timescale 1ns / 100ps

module tb_linear_interp_resampler;
  import lirs_pkg::*;

  localparam int          RESET_CYCLES = 12;
  // covers the longest single sample, with margin
  localparam int          IDLE_GUARD   = 300;
  localparam int          RAND_ITEMS   = 330;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [SAMPLE_W-1:0] value;
    logic                run_last;
    logic                done;
  } slot_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    reg_idx_e           idx;
    logic [PDATA_W-1:0] data;
    logic               typed;
    slot_t              want;
  } row_t;

  localparam slot_t NO_SLOT = '0;

  localparam int SCRIPT_ROWS = 34;
  localparam row_t SCRIPT [SCRIPT_ROWS] = '{
    // reset rates, equal rates
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h007F_FFFF, 1'b1, '{22'd0, 24'h7F_FFFF, 1'b1, 1'b0}},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0080_0000, 1'b1, '{22'd1, 24'h80_0000, 1'b1, 1'b0}},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0000_0001, 1'b0, NO_SLOT},
    // shrink length mid-block: next sample ends it
    '{ROW_CFG,    REG_BLOCK_LEN, 32'd2,         1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0012_3456, 1'b0, NO_SLOT},
    // huge upsample ratio, run capped at MAX_RUN
    '{ROW_CFG,    REG_SRC_RATE,  32'd1,         1'b0, NO_SLOT},
    '{ROW_CFG,    REG_TGT_RATE,  32'h0003_FFFF, 1'b0, NO_SLOT},
    '{ROW_CFG,    REG_BLOCK_LEN, 32'd3,         1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h007F_FFFF, 1'b1, '{22'd0, 24'h7F_FFFF, 1'b1, 1'b0}},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0080_0000, 1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h007F_FFFF, 1'b0, NO_SLOT},
    // zero source rate and zero length: every sample is a one-sample block
    '{ROW_CFG,    REG_SRC_RATE,  32'd0,         1'b0, NO_SLOT},
    '{ROW_CFG,    REG_BLOCK_LEN, 32'd0,         1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0000_0000, 1'b1, '{22'd0, 24'h00_0000, 1'b1, 1'b1}},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h00FF_FFFF, 1'b1, '{22'd0, 24'hFF_FFFF, 1'b1, 1'b1}},
    // downsample overrun, block ends silently
    '{ROW_CFG,    REG_SRC_RATE,  32'd3,         1'b0, NO_SLOT},
    '{ROW_CFG,    REG_TGT_RATE,  32'd2,         1'b0, NO_SLOT},
    '{ROW_CFG,    REG_BLOCK_LEN, 32'd4,         1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0011_1111, 1'b1, '{22'd0, 24'h11_1111, 1'b1, 1'b0}},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0022_2222, 1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0033_3333, 1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0044_4444, 1'b0, NO_SLOT},
    // zero output limit, then switch to upsampling mid-block
    '{ROW_CFG,    REG_SRC_RATE,  32'h0003_FFFF, 1'b0, NO_SLOT},
    '{ROW_CFG,    REG_TGT_RATE,  32'd1,         1'b0, NO_SLOT},
    '{ROW_CFG,    REG_BLOCK_LEN, 32'h0000_FFFF, 1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0055_5555, 1'b1, '{22'd0, 24'h55_5555, 1'b1, 1'b0}},
    '{ROW_CFG,    REG_SRC_RATE,  32'd1,         1'b0, NO_SLOT},
    '{ROW_CFG,    REG_TGT_RATE,  32'h0003_FFFF, 1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0066_6666, 1'b0, NO_SLOT},
    '{ROW_CFG,    REG_BLOCK_LEN, 32'd1,         1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0080_0000, 1'b0, NO_SLOT},
    // output limit saturates
    '{ROW_CFG,    REG_BLOCK_LEN, 32'h0000_FFFF, 1'b0, NO_SLOT},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h007F_FFFF, 1'b1, '{22'd0, 24'h7F_FFFF, 1'b1, 1'b0}},
    '{ROW_SAMPLE, REG_SRC_RATE,  32'h0080_0000, 1'b0, NO_SLOT}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [POS_W-1:0]    out_position_o;
  logic [SAMPLE_W-1:0] sample_out_o;
  logic                run_last_o;
  logic                block_done_o;

  // model copy of registers and block state
  logic [RATE_W-1:0]   cfg_src;
  logic [RATE_W-1:0]   cfg_tgt;
  logic [LEN_W-1:0]    cfg_len;
  logic [SAMPLE_W-1:0] prev_smp;
  int unsigned         in_cnt;
  logic [POS_W-1:0]    last_pos;
  logic [POS_W-1:0]    out_lim;
  logic                stopped;

  slot_t       pending_slots[$];
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned samples_sent = 0;
  int unsigned longest_run = 0;
  int unsigned cycle_cnt = 0;
  logic        no_idle;
  logic        dirty;

  linear_interp_resampler i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_position_o (out_position_o),
    .sample_out_o   (sample_out_o),
    .run_last_o     (run_last_o),
    .block_done_o   (block_done_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_linear_interp_resampler failed");
      $finish;
    end
  end

  // Expected slots for one accepted input sample.
  task automatic resample_step(input logic [SAMPLE_W-1:0] smp);
    longint          cur, prev_v, v;
    longint unsigned src, tgt, len, k, last, np, lim, lim_top, t;
    logic            block_ends;
    slot_t           run[$];
    cur        = $signed(smp);
    prev_v     = $signed(prev_smp);
    src        = (cfg_src == 0) ? 1 : cfg_src;
    tgt        = cfg_tgt;
    len        = (cfg_len == 0) ? 1 : cfg_len;
    k          = in_cnt;
    block_ends = 1'b0;
    if (k == 0) begin
      lim      = tgt * len / src;
      out_lim  = (lim > POS_MAX) ? POS_MAX : POS_W'(lim);
      stopped  = 1'b0;
      last_pos = '0;
      run.push_back({POS_W'(0), smp, 2'b00});
    end else if (!stopped) begin
      last = last_pos;
      if (tgt <= src) begin
        if (k * tgt >= (last + 1) * src) begin
          if (last + 1 >= out_lim) begin
            stopped = 1'b1;
          end else begin
            last_pos = POS_W'(last + 1);
            run.push_back({last_pos, smp, 2'b00});
          end
        end
      end else begin
        np = (k * tgt + src - 1) / src;
        lim_top = out_lim;
        if (lim_top == 0) np = 0;
        else if (np > lim_top - 1) np = lim_top - 1;
        if (np > last + MAX_RUN) np = last + MAX_RUN;
        if (np < last) np = last;
        for (t = last + 1; t < np; t++) begin
          // quotient truncates toward zero
          v = prev_v + ((cur - prev_v) * longint'(t - last)) / longint'(np - last);
          run.push_back({POS_W'(t), SAMPLE_W'(v), 2'b00});
        end
        run.push_back({POS_W'(np), smp, 2'b00});
        last_pos = POS_W'(np);
      end
    end
    prev_smp = smp;
    in_cnt++;
    if (in_cnt >= len) begin
      in_cnt     = 0;
      block_ends = 1'b1;
    end
    foreach (run[i]) run[i].done = block_ends;
    if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
    if (run.size() > longest_run) longest_run = run.size();
    foreach (run[i]) pending_slots.push_back(run[i]);
  endtask

  // Drain everything in flight before touching the registers.
  task automatic settle();
    if (dirty) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      while (pending_slots.size() != 0) @(posedge clk_i);
      repeat (IDLE_GUARD) @(posedge clk_i);
      dirty = 1'b0;
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] data);
    settle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SRC_RATE:  cfg_src = data[RATE_W-1:0];
      REG_TGT_RATE:  cfg_tgt = data[RATE_W-1:0];
      REG_BLOCK_LEN: cfg_len = data[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic typed,
                             input slot_t want);
    int unsigned gap;
    int          base;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_in_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    base = pending_slots.size();
    resample_step(smp);
    // typed rows replace the model's answer, the model still tracks state
    if (typed) begin
      while (pending_slots.size() > base) void'(pending_slots.pop_back());
      pending_slots.push_back(want);
    end
    samples_sent++;
    dirty = 1'b1;
  endtask

  function automatic logic [RATE_W-1:0] pick_common();
    case ($urandom_range(0, 7))
      0:       return 18'd8000;
      1:       return 18'd11025;
      2:       return 18'd16000;
      3:       return 18'd22050;
      4:       return 18'd44100;
      5:       return 18'd96000;
      6:       return 18'd192000;
      default: return 18'd48000;
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return RATE_W'(1);
      2:       return '1;
      default: return RATE_W'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin : result_check
    slot_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_position_o, sample_out_o, run_last_o, block_done_o};
      if (pending_slots.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pos %0d value %h last %b done %b", $time,
                 got.pos, got.value, got.run_last, got.done);
      end else begin
        want = pending_slots.pop_front();
        results_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: want pos %0d val %h last %b done %b, got pos %0d val %h last %b done %b",
                   $time, want.pos, want.value, want.run_last, want.done,
                   got.pos, got.value, got.run_last, got.done);
        end
      end
    end
  end

  initial begin : result_stalls
    int unsigned hold;
    logic        late;
    @(posedge rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 11);
      late = $urandom_range(0, 1);
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        // sometimes hold until a result is actually waiting
        if (late) do @(posedge clk_i); while (!out_valid_o);
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : stimulus
    logic [RATE_W-1:0]   src, tgt;
    logic [LEN_W-1:0]    len;
    logic [SAMPLE_W-1:0] smp;
    int unsigned         len_eff, n_items, rand_sent, phases;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    out_stall_i = 1'b0;
    no_idle     = 1'b0;
    dirty       = 1'b0;
    cfg_src     = SRC_RATE_RST;
    cfg_tgt     = TGT_RATE_RST;
    cfg_len     = BLOCK_LEN_RST;
    prev_smp    = '0;
    in_cnt      = 0;
    last_pos    = '0;
    out_lim     = '0;
    stopped     = 1'b0;
    smp         = '0;
    rand_sent   = 0;
    phases      = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) write_reg(SCRIPT[i].idx, SCRIPT[i].data);
      else send_sample(SCRIPT[i].data[SAMPLE_W-1:0], SCRIPT[i].typed, SCRIPT[i].want);
    end

    while (rand_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          src = pick_common();
          tgt = src;
        end
        2, 3: begin
          src = pick_common();
          tgt = pick_common();
        end
        4, 5: begin
          src = RATE_W'($urandom_range(1, 4000));
          tgt = RATE_W'(src * $urandom_range(2, 63));
        end
        6, 7: begin
          tgt = RATE_W'($urandom_range(1, 4000));
          src = RATE_W'(tgt * $urandom_range(2, 63));
        end
        8: begin
          src = pick_extreme();
          tgt = pick_extreme();
        end
        default: begin
          src = RATE_W'($urandom);
          tgt = RATE_W'($urandom);
        end
      endcase
      case ($urandom_range(0, 19))
        0, 1:    len = '0;
        2:       len = '1;
        3, 4:    len = LEN_W'($urandom_range(13, 65535));
        default: len = LEN_W'($urandom_range(1, 12));
      endcase
      len_eff = (len == 0) ? 1 : len;
      // mostly whole blocks; some phases stop partway into a block
      if (len_eff <= 12) n_items = len_eff * $urandom_range(1, 3);
      else n_items = $urandom_range(4, 20);
      if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, 5);

      // upper data bits carry junk the registers must drop
      if (phases == 0 || $urandom_range(0, 3) != 0)
        write_reg(REG_SRC_RATE, {14'($urandom), src});
      if (phases == 0 || $urandom_range(0, 3) != 0)
        write_reg(REG_TGT_RATE, {14'($urandom), tgt});
      if (phases == 0 || $urandom_range(0, 3) != 0)
        write_reg(REG_BLOCK_LEN, {16'($urandom), len});
      no_idle = ($urandom_range(0, 3) == 0);

      repeat (n_items) begin
        case ($urandom_range(0, 9))
          0:       smp = 24'h7F_FFFF;
          1:       smp = 24'h80_0000;
          2:       smp = smp + SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
          default: smp = SAMPLE_W'($urandom);
        endcase
        send_sample(smp, 1'b0, NO_SLOT);
        rand_sent++;
      end
      phases++;
    end

    settle();
    $display("%0d samples over %0d random settings plus the directed script, %0d results checked",
             samples_sent, phases, results_checked);
    $display("longest interpolation run from one sample: %0d results", longest_run);
    if (errors == 0) begin
      $display("tb_linear_interp_resampler passed");
    end else begin
      $display("tb_linear_interp_resampler failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lirs_pkg.sv
hdl/linear_interp_resampler.sv
bench/tb_linear_interp_resampler.sv
